// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the contrast stretch block.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge except those during reset.
`define MMCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MMCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mmcs_pkg.sv =====
// Package for the min/max contrast stretch block: widths, constants, codes,
// and the command/status structs between controller and datapath. No dependencies.
package mmcs_pkg;

    localparam int PIX_W     = 8;
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int LANES     = 3;

    localparam logic [PIX_W-1:0] FULL_SCALE = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] ZERO_PIX   = '0;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_STRETCH = 1'b1;

    typedef struct packed {
        logic fold;
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/rgb_min_max_contrast_stretch_core.sv =====
// Min/max contrast stretch of 8-bit RGB pixels. A measure beat (command 0) does not stall
// the input and folds the pixel's smallest and largest channel into the running statistics,
// clearing them first when start_frame is set. A stretch beat (command 1) stalls the input
// until its result is written: the beat is loaded, then the restoring dividers produce
// one quotient bit per cycle in all three channels at once, and then the output register
// is written, which may wait while the result is stalled.
// Depends on mmcs_pkg, mmcs_ctrl and mmcs_dp.
module rgb_min_max_contrast_stretch_core
    import mmcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_command,
    input  logic             i_start_frame,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_red_out,
    output logic [PIX_W-1:0] o_green_out,
    output logic [PIX_W-1:0] o_blue_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mmcs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_stall   (o_stall),
        .o_cmd     (dp_cmd)
    );

    mmcs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_start_frame (i_start_frame),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_out_stall   (i_stall),
        .o_stat        (dp_stat),
        .o_valid       (o_valid),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

endmodule

// ===== rtl/mmcs_ctrl.sv =====
// Controller state machine of the contrast stretch block.
// Depends on mmcs_pkg; drives the datapath through t_dp_cmd and reads t_dp_stat.
module mmcs_ctrl
    import mmcs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    output logic     o_stall,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_STRETCH) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = '0;
                        n_state    = S_DIV;
                    end else begin
                        o_cmd.fold = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/mmcs_dp.sv =====
// Datapath of the contrast stretch block: running min/max, three restoring
// dividers and the output register. Depends on mmcs_pkg.
module mmcs_dp
    import mmcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic             i_start_frame,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    input  logic             i_out_stall,
    output t_dp_stat         o_stat,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_red_out,
    output logic [PIX_W-1:0] o_green_out,
    output logic [PIX_W-1:0] o_blue_out
);

    logic [PIX_W-1:0] r_max, r_min, n_max, n_min;
    logic [PIX_W-1:0] r_div;
    logic [PIX_W-1:0] r_rem [LANES];
    logic [PIX_W-1:0] r_num [LANES];
    logic             r_zero [LANES];
    logic             r_sat [LANES];
    logic [PIX_W-1:0] r_out [LANES];
    logic             r_out_valid;

    logic [PIX_W-1:0]   pix [LANES];
    logic [PIX_W-1:0]   pmin, pmax, base_min, base_max;
    logic               degen;
    logic [PIX_W-1:0]   diff [LANES];
    logic [2*PIX_W-1:0] prod [LANES];
    logic [PIX_W:0]     trial [LANES];
    logic [PIX_W:0]     trial_sub [LANES];
    logic [PIX_W-1:0]   n_rem [LANES];
    logic [PIX_W-1:0]   n_num [LANES];

    assign pix[0] = i_red;
    assign pix[1] = i_green;
    assign pix[2] = i_blue;

    always_comb begin
        pmin = pix[0];
        pmax = pix[0];
        for (int k = 1; k < LANES; k++) begin
            if (pix[k] < pmin) pmin = pix[k];
            if (pix[k] > pmax) pmax = pix[k];
        end
        base_min = i_start_frame ? FULL_SCALE : r_min;
        base_max = i_start_frame ? ZERO_PIX : r_max;
        n_min    = (pmin < base_min) ? pmin : base_min;
        n_max    = (pmax > base_max) ? pmax : base_max;
    end

    assign degen = (r_max <= r_min);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            diff[k]      = pix[k] - r_min;
            prod[k]      = {diff[k], ZERO_PIX} - {ZERO_PIX, diff[k]};
            trial[k]     = {r_rem[k], r_num[k][PIX_W-1]};
            trial_sub[k] = trial[k] - {1'b0, r_div};
            if (trial[k] >= {1'b0, r_div}) begin
                n_rem[k] = trial_sub[k][PIX_W-1:0];
                n_num[k] = {r_num[k][PIX_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[k][PIX_W-1:0];
                n_num[k] = {r_num[k][PIX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= ZERO_PIX;
            r_min <= FULL_SCALE;
        end else if (i_cmd.fold) begin
            r_max <= n_max;
            r_min <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= r_max - r_min;
            for (int k = 0; k < LANES; k++) begin
                r_rem[k]  <= prod[k][2*PIX_W-1:PIX_W];
                r_num[k]  <= prod[k][PIX_W-1:0];
                r_zero[k] <= degen || (pix[k] < r_min);
                r_sat[k]  <= (pix[k] >= r_max);
            end
        end else if (i_cmd.step) begin
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int k = 0; k < LANES; k++) begin
                if (r_zero[k]) begin
                    r_out[k] <= ZERO_PIX;
                end else if (r_sat[k]) begin
                    r_out[k] <= FULL_SCALE;
                end else begin
                    r_out[k] <= r_num[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_valid         = r_out_valid;
    assign o_red_out       = r_out[0];
    assign o_green_out     = r_out[1];
    assign o_blue_out      = r_out[2];

endmodule

// ===== rtl/mmcs_checker.sv =====
// Port-level checker for the contrast stretch core, bound to the top level.
// Depends on mmcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmcs_checker
    import mmcs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_command,
    input logic             i_start_frame,
    input logic [PIX_W-1:0] i_red,
    input logic [PIX_W-1:0] i_green,
    input logic [PIX_W-1:0] i_blue,
    input logic             o_valid,
    input logic             i_stall,
    input logic [PIX_W-1:0] o_red_out,
    input logic [PIX_W-1:0] o_green_out,
    input logic [PIX_W-1:0] o_blue_out
);

    `MMCS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out), "stalled result beat changed")
    `MMCS_ASSERT(a_measure_silent, i_clk, i_rst_n, i_valid && !o_stall && (i_command == CMD_MEASURE) |=> !$rose(o_valid), "measure beat produced a result")
    `MMCS_ASSERT(a_stretch_busy, i_clk, i_rst_n, i_valid && !o_stall && (i_command == CMD_STRETCH) |=> o_stall, "input not stalled while stretching")
    `MMCS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "block not idle after reset")

endmodule

bind rgb_min_max_contrast_stretch_core mmcs_checker u_mmcs_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for rgb_min_max_contrast_stretch_core: directed and random measure and
// stretch beats; each stretch result is checked against a predictor of the running min/max and the stretch math.
// Depends on mmcs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import mmcs_pkg::*;

    typedef struct {
        logic             command;
        logic             start_frame;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        int               gap;
        bit               drain_first;
    } t_pixel_beat;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel_out;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             tx_valid = 1'b0;
    logic             tx_command = CMD_MEASURE;
    logic             tx_start = 1'b0;
    logic [PIX_W-1:0] tx_red = ZERO_PIX;
    logic [PIX_W-1:0] tx_green = ZERO_PIX;
    logic [PIX_W-1:0] tx_blue = ZERO_PIX;
    logic             rx_stall = 1'b0;
    logic             rx_hold = 1'b0;
    logic             blk_stall;
    logic             out_valid;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;

    t_pixel_beat      pending_pixels[$];
    t_pixel_out       expected_pixels[$];
    t_pixel_beat      tx_cur;
    logic [PIX_W-1:0] stat_min = FULL_SCALE;
    logic [PIX_W-1:0] stat_max = ZERO_PIX;
    int               items_total = 0;
    int               items_accepted = 0;
    int               results_seen = 0;
    int               mismatches = 0;
    int               tx_wait = 0;
    bit               gap_taken = 0;
    logic             tx_next;
    int               rx_left = 0;
    int               rx_calm = 0;
    int               rx_len;
    logic             rx_next;

    rgb_min_max_contrast_stretch_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (tx_valid),
        .o_stall       (blk_stall),
        .i_command     (tx_command),
        .i_start_frame (tx_start),
        .i_red         (tx_red),
        .i_green       (tx_green),
        .i_blue        (tx_blue),
        .o_valid       (out_valid),
        .i_stall       (rx_stall),
        .o_red_out     (out_red),
        .o_green_out   (out_green),
        .o_blue_out    (out_blue)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] stretch_level(input logic [PIX_W-1:0] c,
                                                       input logic [PIX_W-1:0] lo,
                                                       input logic [PIX_W-1:0] hi);
        int unsigned q;
        if (c < lo) return ZERO_PIX;
        q = ((32'(c) - 32'(lo)) * 32'(FULL_SCALE)) / (32'(hi) - 32'(lo));
        if (q > 32'(FULL_SCALE)) q = 32'(FULL_SCALE);
        return q[PIX_W-1:0];
    endfunction

    function automatic void apply_pixel(input t_pixel_beat p);
        logic [PIX_W-1:0] pmin;
        logic [PIX_W-1:0] pmax;
        t_pixel_out       res;
        pmin = p.red;
        pmax = p.red;
        if (p.green < pmin) pmin = p.green;
        if (p.blue < pmin) pmin = p.blue;
        if (p.green > pmax) pmax = p.green;
        if (p.blue > pmax) pmax = p.blue;
        if (p.command == CMD_MEASURE) begin
            if (p.start_frame) begin
                stat_max = ZERO_PIX;
                stat_min = FULL_SCALE;
            end
            if (pmax > stat_max) stat_max = pmax;
            if (pmin < stat_min) stat_min = pmin;
        end else begin
            if (stat_max <= stat_min) begin
                res.red = ZERO_PIX;
                res.green = ZERO_PIX;
                res.blue = ZERO_PIX;
            end else begin
                res.red = stretch_level(p.red, stat_min, stat_max);
                res.green = stretch_level(p.green, stat_min, stat_max);
                res.blue = stretch_level(p.blue, stat_min, stat_max);
            end
            expected_pixels.push_back(res);
        end
    endfunction

    function automatic void push_pixel(input logic cmd, input logic start,
                                       input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                       input logic [PIX_W-1:0] b, input bit quiet,
                                       input bit drain);
        t_pixel_beat p;
        p.command = cmd;
        p.start_frame = start;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.gap = quiet ? 0 : idle_len();
        p.drain_first = drain;
        pending_pixels.push_back(p);
    endfunction

    function automatic void check_pixel_out();
        t_pixel_out want;
        if (expected_pixels.size() == 0) begin
            $error("unexpected result beat: red_out %0d green_out %0d blue_out %0d",
                   out_red, out_green, out_blue);
            mismatches++;
            return;
        end
        want = expected_pixels.pop_front();
        if (out_red !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, out_red);
            mismatches++;
        end
        if (out_green !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, out_green);
            mismatches++;
        end
        if (out_blue !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, out_blue);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (tx_valid && !blk_stall) begin
                apply_pixel(tx_cur);
                items_accepted <= items_accepted + 1;
            end
            if (!tx_valid || !blk_stall) begin
                tx_next = 1'b0;
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (pending_pixels.size() != 0) begin
                    if (!gap_taken && pending_pixels[0].gap > 0) begin
                        tx_wait = pending_pixels[0].gap - 1;
                        gap_taken = 1;
                    end else if (!(pending_pixels[0].drain_first
                                   && expected_pixels.size() != 0)) begin
                        tx_cur = pending_pixels.pop_front();
                        gap_taken = 0;
                        tx_next = 1'b1;
                        tx_command <= tx_cur.command;
                        tx_start <= tx_cur.start_frame;
                        tx_red <= tx_cur.red;
                        tx_green <= tx_cur.green;
                        tx_blue <= tx_cur.blue;
                    end
                end
                tx_valid <= tx_next;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_stall <= 1'b0;
        end else begin
            if (out_valid && !rx_stall) begin
                check_pixel_out();
                results_seen <= results_seen + 1;
            end
            rx_next = 1'b0;
            if (rx_hold) begin
                rx_next = 1'b1;
            end else if (rx_left > 0) begin
                rx_left--;
                rx_next = 1'b1;
            end else if (rx_calm > 0) begin
                rx_calm--;
            end else begin
                if ($urandom_range(0, 199) == 0) rx_calm = 100;
                rx_len = idle_len();
                if (rx_len > 0) begin
                    rx_left = rx_len - 1;
                    rx_next = 1'b1;
                end
            end
            rx_stall <= rx_next;
        end
    end

    initial begin
        wait (rst_n === 1'b1);
        while (results_seen < 60) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int          nmeas;
        int          nstr;
        int          lo;
        int          hi;
        int          waited;
        bit          quiet;
        bit          drain;
        logic        rc;
        logic        rs;

        // Directed beats: degenerate ranges, clipping at both ends, ignored start_frame.
        push_pixel(CMD_STRETCH, 1'b0, 8'd255, 8'd0, 8'd128, 0, 0);
        push_pixel(CMD_MEASURE, 1'b0, 8'd10, 8'd200, 8'd50, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'd0, 8'd255, 8'd105, 0, 0);
        push_pixel(CMD_STRETCH, 1'b1, 8'd10, 8'd200, 8'd9, 0, 0);
        push_pixel(CMD_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'd0, 8'd1, 8'd255, 0, 0);
        push_pixel(CMD_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'd0, 8'd255, 8'd128, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'hAA, 8'h55, 8'h01, 0, 0);
        push_pixel(CMD_MEASURE, 1'b1, 8'd100, 8'd100, 8'd100, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'd99, 8'd100, 8'd101, 0, 0);
        push_pixel(CMD_MEASURE, 1'b1, 8'h80, 8'h7F, 8'h81, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'h7F, 8'h80, 8'h81, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'h00, 8'hFF, 8'h82, 0, 0);
        push_pixel(CMD_MEASURE, 1'b1, 8'hFE, 8'h01, 8'h55, 0, 0);
        push_pixel(CMD_MEASURE, 1'b0, 8'h02, 8'hFD, 8'hAA, 0, 0);
        push_pixel(CMD_STRETCH, 1'b0, 8'hFF, 8'h00, 8'h80, 0, 0);
        push_pixel(CMD_MEASURE, 1'b1, 8'h55, 8'hAA, 8'h0F, 0, 0);
        push_pixel(CMD_STRETCH, 1'b1, 8'hF0, 8'h0F, 8'h5A, 0, 0);

        drain = 1;
        while (pending_pixels.size() < 950) begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 99) < 85) begin
                lo = $urandom_range(0, 255);
                hi = ($urandom_range(0, 3) == 0)
                     ? $urandom_range(lo, (lo + 4 > 255) ? 255 : lo + 4)
                     : $urandom_range(lo, 255);
                nmeas = $urandom_range(1, 6);
                nstr = $urandom_range(1, 8);
                for (int k = 0; k < nmeas; k++) begin
                    push_pixel(CMD_MEASURE, (k == 0) ? 1'b1 : 1'b0,
                               8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)),
                               8'($urandom_range(lo, hi)), quiet, (k == 0) && drain);
                end
                for (int k = 0; k < nstr; k++) begin
                    if ($urandom_range(0, 9) < 7)
                        push_pixel(CMD_STRETCH, 1'($urandom_range(0, 1)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), quiet, 0);
                    else
                        push_pixel(CMD_STRETCH, 1'b0,
                                   8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)),
                                   8'($urandom_range(lo, hi)), quiet, 0);
                end
            end else begin
                nmeas = $urandom_range(1, 4);
                for (int k = 0; k < nmeas; k++) begin
                    rc = ($urandom_range(0, 1) == 0) ? CMD_MEASURE : CMD_STRETCH;
                    rs = 1'($urandom_range(0, 1));
                    push_pixel(rc, rs, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), quiet, 0);
                end
            end
            drain = ($urandom_range(0, 24) == 0);
        end
        items_total = pending_pixels.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_total) @(posedge clk);
        waited = 0;
        while (expected_pixels.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d expected result beats never arrived", expected_pixels.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
